// ===== sv/hcs_pkg.sv =====
package hcs_pkg;

  localparam int unsigned NUM_CHANNELS = 16;
  localparam int unsigned IDX_W        = $clog2(NUM_CHANNELS);
  localparam int unsigned SLOT_W       = 6;
  localparam int unsigned DVD_W        = 32;
  localparam int unsigned DSR_W        = 19;

  localparam logic [31:0]       LCG_MUL      = 32'd1664525;
  localparam logic [31:0]       LCG_ADD      = 32'd1013904223;
  localparam logic [DSR_W-1:0]  SLOT_TICKS   = DSR_W'(20000 * 16);
  localparam logic [4:0]        BASE_CHANNEL = 5'd11;
  localparam logic [SLOT_W-1:0] LAST_SLOT    = SLOT_W'(2 * NUM_CHANNELS - 2);
  localparam logic [IDX_W-1:0]  LAST_SWAP    = IDX_W'(NUM_CHANNELS - 2);

  // slot = (((clock >> 9) * SLOT_RECIP) >> 25), exact for every 24-bit clock
  localparam int unsigned       SLOT_PRE_SH  = 9;
  localparam int unsigned       SLOT_POST_SH = 25;
  localparam logic [15:0]       SLOT_RECIP   = 16'd53688;

  typedef enum logic [1:0] {
    FUNC_RESEED  = 2'd0,
    FUNC_QUERY   = 2'd1,
    FUNC_ADVANCE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    MODE_FIXED   = 2'd0,
    MODE_CONT    = 2'd1,
    MODE_STARTUP = 2'd2,
    MODE_SPARE   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_DGO,
    S_DIV,
    S_SWRD,
    S_SWJ,
    S_SWI,
    S_QGO,
    S_QDIV,
    S_MODE,
    S_LKRES,
    S_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_ADD,
    OP_DIV_LCG,
    OP_DIV_CLK,
    OP_SWAP_RD,
    OP_WR_J,
    OP_WR_I,
    OP_SLOT_DIV,
    OP_RES_OOR,
    OP_LK_RD,
    OP_RES_LK,
    OP_RES_CNT,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic  in_valid;
    func_t func;
    mode_t mode;
    logic  div_done;
    logic  last_swap;
    logic  oor;
    logic  out_free;
  } sts_t;

endpackage

// ===== sv/hcs_ifs.sv =====
interface hcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] seed;
  logic [23:0] seq_clock;
  logic [4:0]  current_index;

  modport source (output valid, func, seed, seq_clock, current_index, input ready);
  modport sink (input valid, func, seed, seq_clock, current_index, output ready);
endinterface

interface hcs_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] channel;
  logic [4:0] next_index;
  logic       clock_out_of_range;

  modport source (output valid, channel, next_index, clock_out_of_range, input ready);
  modport sink (input valid, channel, next_index, clock_out_of_range, output ready);
endinterface

interface hcs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] hop_mode;

  modport source (output valid, hop_mode, input ready);
  modport sink (input valid, hop_mode, output ready);
endinterface

// ===== sv/hop_channel_sequencer.sv =====
// Accepted word to result: a query takes slot multiply, slot register, mode decode and,
// in continuous mode, a table lookup; an advance takes mode decode and the lookup; an
// ignored word goes straight out. A reseed runs 15 swaps (multiply, add, divider start,
// wait on the serial modulo, read, two writes), so reseeds set the worst case.
// One word in flight; the next word is taken while a result waits on out.
// Synchronous active-low reset: identity permutation, counter zero, mode fixed.
module hop_channel_sequencer (
  input  logic      clk,
  input  logic      rst_n,
  hcs_in_if.sink    in_ch,
  hcs_out_if.source out_ch,
  hcs_cfg_if.sink   cfg_ch
);

  hcs_pkg::cmd_t cmd;
  hcs_pkg::sts_t sts;
  logic          in_ready;

  hcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  hcs_datapath u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_valid               (in_ch.valid),
    .in_func                (in_ch.func),
    .in_seed                (in_ch.seed),
    .in_seq_clock           (in_ch.seq_clock),
    .in_current_index       (in_ch.current_index),
    .cfg_valid              (cfg_ch.valid),
    .cfg_hop_mode           (cfg_ch.hop_mode),
    .out_ready              (out_ch.ready),
    .out_valid              (out_ch.valid),
    .out_channel            (out_ch.channel),
    .out_next_index         (out_ch.next_index),
    .out_clock_out_of_range (out_ch.clock_out_of_range)
  );

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

endmodule

// ===== sv/hcs_div.sv =====
module hcs_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [hcs_pkg::DVD_W-1:0]       dividend,
  input  logic [hcs_pkg::DSR_W-1:0]       divisor,
  output logic                            done,
  output logic [hcs_pkg::DSR_W-1:0]       remainder
);

  localparam int unsigned CNT_W = $clog2(hcs_pkg::DVD_W);

  logic [hcs_pkg::DVD_W-1:0] quot_r;
  logic [hcs_pkg::DSR_W-1:0] rem_r;
  logic [hcs_pkg::DSR_W-1:0] dsr_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      run_r;
  logic                      done_r;
  logic [hcs_pkg::DSR_W:0]   trial;
  logic [hcs_pkg::DSR_W:0]   diff;
  logic                      ge;

  always_comb begin
    trial = {rem_r, quot_r[hcs_pkg::DVD_W-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = trial >= {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(hcs_pkg::DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dsr_r  <= divisor;
    end else if (run_r) begin
      quot_r <= {quot_r[hcs_pkg::DVD_W-2:0], ge};
      rem_r  <= ge ? diff[hcs_pkg::DSR_W-1:0] : trial[hcs_pkg::DSR_W-1:0];
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== sv/hcs_ctrl.sv =====
module hcs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  hcs_pkg::sts_t   sts,
  output hcs_pkg::cmd_t   cmd,
  output logic            in_ready
);

  hcs_pkg::state_t state_r;
  hcs_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hcs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = hcs_pkg::OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      hcs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.op = hcs_pkg::OP_LOAD;
          unique case (sts.func)
            hcs_pkg::FUNC_RESEED:  state_nxt = hcs_pkg::S_MUL;
            hcs_pkg::FUNC_QUERY:   state_nxt = hcs_pkg::S_QGO;
            hcs_pkg::FUNC_ADVANCE: state_nxt = hcs_pkg::S_MODE;
            default:               state_nxt = hcs_pkg::S_FIN;
          endcase
        end
      end
      hcs_pkg::S_MUL: begin
        cmd.op    = hcs_pkg::OP_MUL;
        state_nxt = hcs_pkg::S_ADD;
      end
      hcs_pkg::S_ADD: begin
        cmd.op    = hcs_pkg::OP_ADD;
        state_nxt = hcs_pkg::S_DGO;
      end
      hcs_pkg::S_DGO: begin
        cmd.op    = hcs_pkg::OP_DIV_LCG;
        state_nxt = hcs_pkg::S_DIV;
      end
      hcs_pkg::S_DIV: begin
        if (sts.div_done) begin
          state_nxt = hcs_pkg::S_SWRD;
        end
      end
      hcs_pkg::S_SWRD: begin
        cmd.op    = hcs_pkg::OP_SWAP_RD;
        state_nxt = hcs_pkg::S_SWJ;
      end
      hcs_pkg::S_SWJ: begin
        cmd.op    = hcs_pkg::OP_WR_J;
        state_nxt = hcs_pkg::S_SWI;
      end
      hcs_pkg::S_SWI: begin
        cmd.op    = hcs_pkg::OP_WR_I;
        state_nxt = sts.last_swap ? hcs_pkg::S_FIN : hcs_pkg::S_MUL;
      end
      hcs_pkg::S_QGO: begin
        cmd.op    = hcs_pkg::OP_DIV_CLK;
        state_nxt = hcs_pkg::S_QDIV;
      end
      hcs_pkg::S_QDIV: begin
        cmd.op    = hcs_pkg::OP_SLOT_DIV;
        state_nxt = hcs_pkg::S_MODE;
      end
      hcs_pkg::S_MODE: begin
        unique case (sts.mode)
          hcs_pkg::MODE_CONT: begin
            if (sts.oor) begin
              cmd.op    = hcs_pkg::OP_RES_OOR;
              state_nxt = hcs_pkg::S_FIN;
            end else begin
              cmd.op    = hcs_pkg::OP_LK_RD;
              state_nxt = hcs_pkg::S_LKRES;
            end
          end
          hcs_pkg::MODE_STARTUP: begin
            cmd.op    = hcs_pkg::OP_RES_CNT;
            state_nxt = hcs_pkg::S_FIN;
          end
          default: begin
            state_nxt = hcs_pkg::S_FIN;
          end
        endcase
      end
      hcs_pkg::S_LKRES: begin
        cmd.op    = hcs_pkg::OP_RES_LK;
        state_nxt = hcs_pkg::S_FIN;
      end
      hcs_pkg::S_FIN: begin
        if (sts.out_free) begin
          cmd.op    = hcs_pkg::OP_OUT;
          state_nxt = hcs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = hcs_pkg::S_IDLE;
      end
    endcase
  end

  a_fin_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hcs_pkg::S_FIN && sts.out_free) |=> state_r == hcs_pkg::S_IDLE)
    else $error("result handed over but controller did not return to idle");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == hcs_pkg::S_DIV)
    else $error("divider finished while controller was not waiting");

  a_last_swap_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hcs_pkg::S_SWI && sts.last_swap) |=> state_r == hcs_pkg::S_FIN)
    else $error("shuffle did not end after final swap");

endmodule

// ===== sv/hcs_datapath.sv =====
module hcs_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hcs_pkg::cmd_t        cmd,
  output hcs_pkg::sts_t        sts,
  input  logic                 in_valid,
  input  logic [1:0]           in_func,
  input  logic [31:0]          in_seed,
  input  logic [23:0]          in_seq_clock,
  input  logic [4:0]           in_current_index,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_hop_mode,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [4:0]           out_channel,
  output logic [4:0]           out_next_index,
  output logic                 out_clock_out_of_range
);

  localparam int unsigned N  = hcs_pkg::NUM_CHANNELS;
  localparam int unsigned IW = hcs_pkg::IDX_W;
  localparam int unsigned SW = hcs_pkg::SLOT_W;

  hcs_pkg::mode_t mode_r;
  hcs_pkg::func_t func_r;
  logic [31:0]    x_r;
  logic [31:0]    prod_r;
  logic [23:0]    clk_r;
  logic [IW-1:0]  i_r;
  logic [IW-1:0]  j_r;
  logic [SW-1:0]  slot_r;
  logic           oor_r;
  logic [7:0]     cnt_r;
  logic [7:0]     cnt_nxt;

  logic [4:0]     chan_r;
  logic [4:0]     nidx_r;
  logic           flag_r;

  logic           out_valid_r;
  logic [4:0]     out_chan_r;
  logic [4:0]     out_nidx_r;
  logic           out_flag_r;

  logic [IW-1:0]  perm_mem [N];
  logic [N-1:0]   perm_vld_r;
  logic [IW-1:0]  rd_a_r;
  logic [IW-1:0]  rd_b_r;
  logic [IW-1:0]  addr_a;
  logic [IW-1:0]  addr_b;
  logic [IW-1:0]  tri_idx;
  logic [SW-1:0]  adv_sum;
  logic [4:0]     adv_idx;

  logic                            div_start;
  logic [hcs_pkg::DVD_W-1:0]       div_dvd;
  logic [hcs_pkg::DSR_W-1:0]       div_dsr;
  logic                            div_done;
  logic [hcs_pkg::DSR_W-1:0]       div_rem;

  hcs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    adv_sum = {1'b0, in_current_index} + 1'b1;
    adv_idx = (adv_sum > hcs_pkg::LAST_SLOT) ? 5'd0 : adv_sum[4:0];
    tri_idx = (slot_r < SW'(N)) ? slot_r[IW-1:0]
                                : IW'(hcs_pkg::LAST_SLOT - slot_r);
    addr_a  = (cmd.op == hcs_pkg::OP_LK_RD) ? tri_idx : i_r;
    addr_b  = div_rem[IW-1:0] + i_r;
    cnt_nxt = cnt_r + 1'b1;
    div_start = (cmd.op == hcs_pkg::OP_DIV_LCG);
    div_dvd   = x_r;
    div_dsr   = hcs_pkg::DSR_W'(N) - {{(hcs_pkg::DSR_W-IW){1'b0}}, i_r};
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= hcs_pkg::MODE_FIXED;
      cnt_r       <= '0;
      perm_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode_r <= hcs_pkg::mode_t'(cfg_hop_mode);
      end
      if (cmd.op == hcs_pkg::OP_LOAD && hcs_pkg::func_t'(in_func) == hcs_pkg::FUNC_RESEED) begin
        perm_vld_r <= '0;
      end else if (cmd.op == hcs_pkg::OP_WR_J) begin
        perm_vld_r[j_r] <= 1'b1;
      end else if (cmd.op == hcs_pkg::OP_WR_I) begin
        perm_vld_r[i_r] <= 1'b1;
      end
      if (cmd.op == hcs_pkg::OP_RES_CNT) begin
        cnt_r <= cnt_nxt;
      end
      if (cmd.op == hcs_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // permutation store
  always_ff @(posedge clk) begin
    if (cmd.op == hcs_pkg::OP_WR_J) begin
      perm_mem[j_r] <= rd_a_r;
    end else if (cmd.op == hcs_pkg::OP_WR_I) begin
      perm_mem[i_r] <= rd_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == hcs_pkg::OP_SWAP_RD || cmd.op == hcs_pkg::OP_LK_RD) begin
      rd_a_r <= perm_vld_r[addr_a] ? perm_mem[addr_a] : addr_a;
      rd_b_r <= perm_vld_r[addr_b] ? perm_mem[addr_b] : addr_b;
    end
  end

  // word payload and working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      hcs_pkg::OP_LOAD: begin
        func_r <= hcs_pkg::func_t'(in_func);
        x_r    <= in_seed;
        clk_r  <= in_seq_clock;
        i_r    <= '0;
        oor_r  <= 1'b0;
        slot_r <= {1'b0, adv_idx};
        chan_r <= hcs_pkg::BASE_CHANNEL;
        flag_r <= 1'b0;
        nidx_r <= (hcs_pkg::func_t'(in_func) == hcs_pkg::FUNC_ADVANCE) ? adv_idx : 5'd0;
      end
      hcs_pkg::OP_MUL: begin
        prod_r <= x_r * hcs_pkg::LCG_MUL;
      end
      hcs_pkg::OP_ADD: begin
        x_r <= prod_r + hcs_pkg::LCG_ADD;
      end
      hcs_pkg::OP_DIV_CLK: begin
        prod_r <= ({8'd0, clk_r} >> hcs_pkg::SLOT_PRE_SH) * {16'd0, hcs_pkg::SLOT_RECIP};
      end
      hcs_pkg::OP_SWAP_RD: begin
        j_r <= addr_b;
      end
      hcs_pkg::OP_WR_I: begin
        i_r <= i_r + 1'b1;
      end
      hcs_pkg::OP_SLOT_DIV: begin
        slot_r <= prod_r[hcs_pkg::SLOT_POST_SH +: SW];
        oor_r  <= prod_r[hcs_pkg::SLOT_POST_SH +: SW] > hcs_pkg::LAST_SLOT;
      end
      hcs_pkg::OP_RES_OOR: begin
        chan_r <= hcs_pkg::BASE_CHANNEL;
        flag_r <= (func_r == hcs_pkg::FUNC_QUERY);
      end
      hcs_pkg::OP_RES_LK: begin
        chan_r <= {{(5-IW){1'b0}}, rd_a_r} + hcs_pkg::BASE_CHANNEL;
      end
      hcs_pkg::OP_RES_CNT: begin
        chan_r <= {1'b0, cnt_nxt[7:4]} + hcs_pkg::BASE_CHANNEL;
      end
      hcs_pkg::OP_OUT: begin
        out_chan_r <= chan_r;
        out_nidx_r <= nidx_r;
        out_flag_r <= flag_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.in_valid  = in_valid;
    sts.func      = hcs_pkg::func_t'(in_func);
    sts.mode      = mode_r;
    sts.div_done  = div_done;
    sts.last_swap = (i_r == hcs_pkg::LAST_SWAP);
    sts.oor       = oor_r;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid              = out_valid_r;
  assign out_channel            = out_chan_r;
  assign out_next_index         = out_nidx_r;
  assign out_clock_out_of_range = out_flag_r;

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import hcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 5_000_000;
  localparam int unsigned DRAIN_CYCLES   = 600;
  localparam int unsigned SEG_WORDS      = 150;
  localparam int unsigned TICKS_PER_SLOT = SLOT_TICKS;
  localparam int unsigned TOP_SLOT       = LAST_SLOT;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] seed;
    logic [23:0] seq_clock;
    logic [4:0]  current_index;
  } hop_word_t;

  typedef struct packed {
    logic [4:0] channel;
    logic [4:0] next_index;
    logic       clock_out_of_range;
  } hop_res_t;

  logic clk;
  logic rst_n;

  hcs_in_if  in_bus ();
  hcs_out_if out_bus ();
  hcs_cfg_if cfg_bus ();

  hop_channel_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  hop_word_t   word_q[$];
  hop_res_t    hops_due[$];
  logic [3:0]  perm_m [NUM_CHANNELS];
  logic [7:0]  sweep_cnt;
  mode_t       mode_m;
  mode_t       cfg_word;
  int unsigned cfg_issued     = 0;
  int unsigned cfg_taken      = 0;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_sent     = 0;
  int unsigned hops_checked   = 0;
  int unsigned errors         = 0;
  int unsigned cycles         = 0;

  mode_t phase_modes [3][4] = '{
    '{MODE_CONT,    MODE_STARTUP, MODE_FIXED, MODE_CONT},
    '{MODE_STARTUP, MODE_CONT,    MODE_SPARE, MODE_STARTUP},
    '{MODE_CONT,    MODE_STARTUP, MODE_CONT,  MODE_FIXED}
  };

  function automatic logic [4:0] slot_channel(input int unsigned slot, output logic oor);
    logic [4:0]  ch;
    int unsigned t;
    ch  = BASE_CHANNEL;
    oor = 1'b0;
    case (mode_m)
      MODE_CONT: begin
        if (slot > TOP_SLOT) begin
          oor = 1'b1;
        end else begin
          t  = (slot < NUM_CHANNELS) ? slot : TOP_SLOT - slot;
          ch = 5'(perm_m[t]) + BASE_CHANNEL;
        end
      end
      MODE_STARTUP: begin
        sweep_cnt = sweep_cnt + 8'd1;
        ch = 5'(sweep_cnt >> 4) + BASE_CHANNEL;
      end
      default: ;
    endcase
    return ch;
  endfunction

  function automatic hop_res_t hop_for_word(input hop_word_t w);
    hop_res_t    r;
    logic [31:0] x;
    int unsigned i;
    int unsigned j;
    logic [3:0]  t;
    logic [5:0]  nidx;
    logic        flag_drop;
    r.channel            = BASE_CHANNEL;
    r.next_index         = 5'd0;
    r.clock_out_of_range = 1'b0;
    case (func_t'(w.func))
      FUNC_RESEED: begin
        x = w.seed;
        for (i = 0; i < NUM_CHANNELS; i++) perm_m[i] = 4'(i);
        for (i = 0; i + 1 < NUM_CHANNELS; i++) begin
          x = x * LCG_MUL + LCG_ADD;
          j = x % (NUM_CHANNELS - i) + i;
          t = perm_m[j];
          perm_m[j] = perm_m[i];
          perm_m[i] = t;
        end
      end
      FUNC_QUERY: begin
        r.channel = slot_channel(w.seq_clock / TICKS_PER_SLOT, r.clock_out_of_range);
      end
      FUNC_ADVANCE: begin
        nidx = 6'(w.current_index) + 6'd1;
        if (nidx > LAST_SLOT) nidx = 6'd0;
        r.next_index = nidx[4:0];
        r.channel    = slot_channel(nidx, flag_drop);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [4:0] want,
                                      input logic [4:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic logic [23:0] rand_clock();
    if ($urandom_range(9) < 7) return 24'($urandom_range((TOP_SLOT + 1) * TICKS_PER_SLOT - 1));
    return 24'($urandom());
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles", $time, cycles);
      $display("hop_channel_sequencer test failed");
      $finish;
    end
  end

  always @(posedge clk) begin : drive
    hop_word_t taken;
    hop_word_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        taken.func          = in_bus.func;
        taken.seed          = in_bus.seed;
        taken.seq_clock     = in_bus.seq_clock;
        taken.current_index = in_bus.current_index;
        hops_due.push_back(hop_for_word(taken));
        words_sent++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = word_q.pop_front();
          in_bus.valid         <= 1'b1;
          in_bus.func          <= nxt.func;
          in_bus.seed          <= nxt.seed;
          in_bus.seq_clock     <= nxt.seq_clock;
          in_bus.current_index <= nxt.current_index;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_bus.valid <= 1'b0;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      cfg_bus.valid <= 1'b0;
      mode_m = mode_t'(cfg_bus.hop_mode);
      cfg_taken++;
    end else if (!cfg_bus.valid && cfg_taken != cfg_issued) begin
      cfg_bus.valid    <= 1'b1;
      cfg_bus.hop_mode <= cfg_word;
    end
  end

  always @(posedge clk) begin : monitor
    hop_res_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_bus.valid && out_bus.ready) begin
        if (hops_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual channel %0d index %0d flag %0d",
                   $time, out_bus.channel, out_bus.next_index, out_bus.clock_out_of_range);
          errors++;
        end else begin
          want = hops_due.pop_front();
          check_field("channel", want.channel, out_bus.channel);
          check_field("next_index", want.next_index, out_bus.next_index);
          check_field("clock_out_of_range", 5'(want.clock_out_of_range),
                      5'(out_bus.clock_out_of_range));
          hops_checked++;
        end
      end
    end
  end

  task automatic queue_word(input func_t f, input logic [31:0] seed,
                            input logic [23:0] ticks, input logic [4:0] idx);
    hop_word_t w;
    w.func          = f;
    w.seed          = seed;
    w.seq_clock     = ticks;
    w.current_index = idx;
    word_q.push_back(w);
  endtask

  task automatic settle();
    while (word_q.size() != 0 || in_bus.valid || hops_due.size() != 0) @(negedge clk);
  endtask

  task automatic set_mode(input mode_t m);
    settle();
    cfg_word = m;
    cfg_issued++;
    while (cfg_taken != cfg_issued) @(negedge clk);
  endtask

  task automatic add_random(input int unsigned n);
    int unsigned made;
    int unsigned pick;
    int unsigned walk_len;
    int unsigned idx;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        // reseed, then hop through consecutive slots
        queue_word(FUNC_RESEED, $urandom(), rand_clock(), 5'($urandom_range(31)));
        idx      = $urandom_range(TOP_SLOT);
        walk_len = $urandom_range(20, 4);
        repeat (walk_len) begin
          if ($urandom_range(1) == 1)
            queue_word(FUNC_ADVANCE, $urandom(), rand_clock(), 5'(idx));
          else
            queue_word(FUNC_QUERY, $urandom(),
                       24'(idx * TICKS_PER_SLOT + $urandom_range(TICKS_PER_SLOT - 1)),
                       5'($urandom_range(31)));
          idx = (idx == TOP_SLOT) ? 0 : idx + 1;
        end
        made += walk_len + 1;
      end else if (pick < 20) begin
        queue_word(FUNC_RESEED, $urandom(), rand_clock(), 5'($urandom_range(31)));
        made++;
      end else if (pick < 58) begin
        queue_word(FUNC_QUERY, $urandom(), rand_clock(), 5'($urandom_range(31)));
        made++;
      end else if (pick < 95) begin
        queue_word(FUNC_ADVANCE, $urandom(), rand_clock(), 5'($urandom_range(31)));
        made++;
      end else begin
        queue_word(FUNC_NONE, $urandom(), rand_clock(), 5'($urandom_range(31)));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned seg;
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.func          = 2'd0;
    in_bus.seed          = 32'd0;
    in_bus.seq_clock     = 24'd0;
    in_bus.current_index = 5'd0;
    out_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.hop_mode     = 2'd0;
    for (int unsigned k = 0; k < NUM_CHANNELS; k++) perm_m[k] = 4'(k);
    sweep_cnt = 8'd0;
    mode_m    = MODE_FIXED;
    cfg_word  = MODE_FIXED;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_gap_pct   = 7;
    recv_stall_pct = 50;

    // fixed mode straight out of reset
    queue_word(FUNC_QUERY, 32'd0, 24'd0, 5'd0);
    queue_word(FUNC_QUERY, 32'hFFFFFFFF, 24'hFFFFFF, 5'd31);
    queue_word(FUNC_ADVANCE, 32'd0, 24'd0, 5'd30);

    // identity table, slot edges, wrap and out-of-range clocks, then an ignored word and reseeds
    set_mode(MODE_CONT);
    queue_word(FUNC_QUERY, 32'd0, 24'd0, 5'd0);
    queue_word(FUNC_QUERY, 32'd0, 24'(15 * TICKS_PER_SLOT), 5'd0);
    queue_word(FUNC_QUERY, 32'd0, 24'(16 * TICKS_PER_SLOT), 5'd0);
    queue_word(FUNC_QUERY, 32'd0, 24'(31 * TICKS_PER_SLOT - 1), 5'd0);
    queue_word(FUNC_QUERY, 32'd0, 24'(31 * TICKS_PER_SLOT), 5'd0);
    queue_word(FUNC_QUERY, 32'd0, 24'hFFFFFF, 5'd0);
    queue_word(FUNC_ADVANCE, 32'd0, 24'd0, 5'd0);
    queue_word(FUNC_ADVANCE, 32'd0, 24'hFFFFFF, 5'd29);
    queue_word(FUNC_ADVANCE, 32'd0, 24'd0, 5'd30);
    queue_word(FUNC_ADVANCE, 32'd0, 24'd0, 5'd31);
    queue_word(FUNC_NONE, 32'hFFFFFFFF, 24'hFFFFFF, 5'd31);
    queue_word(FUNC_RESEED, 32'd0, 24'd0, 5'd0);
    queue_word(FUNC_QUERY, 32'd0, 24'(5 * TICKS_PER_SLOT), 5'd0);
    queue_word(FUNC_RESEED, 32'hFFFFFFFF, 24'hFFFFFF, 5'd31);
    queue_word(FUNC_QUERY, 32'd0, 24'(20 * TICKS_PER_SLOT + 7), 5'd0);
    queue_word(FUNC_ADVANCE, 32'd0, 24'd0, 5'd14);

    set_mode(MODE_STARTUP);
    queue_word(FUNC_QUERY, 32'd0, 24'd0, 5'd0);
    queue_word(FUNC_ADVANCE, 32'd0, 24'd0, 5'd7);
    queue_word(FUNC_QUERY, 32'd0, 24'hFFFFFF, 5'd0);
    queue_word(FUNC_RESEED, 32'h12345678, 24'd0, 5'd0);

    set_mode(MODE_SPARE);
    queue_word(FUNC_QUERY, 32'd0, 24'(3 * TICKS_PER_SLOT), 5'd0);
    queue_word(FUNC_ADVANCE, 32'd0, 24'd0, 5'd3);

    for (ph = 0; ph < 3; ph++) begin
      for (seg = 0; seg < 4; seg++) begin
        set_mode(phase_modes[ph][seg]);
        send_gap_pct   = (ph == 0) ? 7 : (ph == 1) ? 50 : 0;
        recv_stall_pct = (ph == 0) ? 50 : (ph == 1) ? 7 : 0;
        add_random(SEG_WORDS);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d words sent and %0d results checked in %0d cycles", words_sent, hops_checked,
             cycles);
    $display("covered reseeds, queries, advances and ignored words in all four modes, %0d errors",
             errors);
    if (errors == 0) begin
      $display("hop_channel_sequencer test passed");
    end else begin
      $display("hop_channel_sequencer test failed");
    end
    $finish;
  end

endmodule

// ===== hop_channel_sequencer.f =====
sv/hcs_pkg.sv
sv/hcs_ifs.sv
sv/hcs_div.sv
sv/hcs_ctrl.sv
sv/hcs_datapath.sv
sv/hop_channel_sequencer.sv
tb/testbench.sv
